>>> rtl/sparse_image_block_offset_rank_defines.svh
// Assertion macros for the sparse image block offset unit
`ifndef SPARSE_IMAGE_BLOCK_OFFSET_RANK_DEFINES_SVH
`define SPARSE_IMAGE_BLOCK_OFFSET_RANK_DEFINES_SVH
// a |-> b on clk, disabled in reset
`define SIBOR_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// a |=> b on clk, disabled in reset
`define SIBOR_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

>>> rtl/sibor_pkg.sv
// ---------------------------------------------------------------------------
// sibor_pkg
// Shared constants and types of the block offset unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sibor_pkg;
    localparam int MAX_WORDS = 1024;
    localparam int WORD_BITS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int RANK_W    = 17;
    localparam int OFF_W     = 48;
    localparam int CFG_W     = 32;

    localparam logic [2:0] REG_BLK_BYTES     = 3'd0;
    localparam logic [2:0] REG_CK_BYTES      = 3'd1;
    localparam logic [2:0] REG_BLOCKS_PER_CK = 3'd2;
    localparam logic [2:0] REG_DATA_BASE     = 3'd3;
    localparam logic [2:0] REG_WORDS_PER_GRP = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEYOND = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    function automatic logic [6:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + {6'd0, v[i]};
        end
        return n;
    endfunction
endpackage

>>> rtl/sibor_ram.sv
// ---------------------------------------------------------------------------
// sibor_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sibor_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/sibor_divider.sv
// ---------------------------------------------------------------------------
// sibor_divider
// Restoring divider, one quotient bit a cycle: 17-bit dividend, 21-bit divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sibor_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [sibor_pkg::RANK_W-1:0] dividend,
    input  logic [20:0]                 divisor,
    output logic                        done,
    output logic [sibor_pkg::RANK_W-1:0] quotient
);
    logic [sibor_pkg::RANK_W-1:0] q_reg;
    logic [21:0]                  r_reg;
    logic [4:0]                   n_reg;
    logic                         run_reg;
    logic [21:0]                  trial;

    assign trial    = {r_reg[20:0], q_reg[sibor_pkg::RANK_W-1]};
    assign quotient = q_reg;
    assign done     = run_reg && (n_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            n_reg   <= '0;
            q_reg   <= '0;
            r_reg   <= '0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            n_reg   <= 5'(sibor_pkg::RANK_W);
            q_reg   <= dividend;
            r_reg   <= '0;
        end
        else if (run_reg && n_reg != 5'd0)
        begin
            n_reg <= n_reg - 5'd1;
            if (trial >= {1'b0, divisor})
            begin
                r_reg <= trial - {1'b0, divisor};
                q_reg <= {q_reg[sibor_pkg::RANK_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[sibor_pkg::RANK_W-2:0], 1'b0};
            end
        end
        else
        begin
            run_reg <= 1'b0;
        end
    end
endmodule

>>> rtl/sparse_image_block_offset_rank.sv
// ---------------------------------------------------------------------------
// sparse_image_block_offset_rank
// Bitmap rank with group prefix counts; block number to image byte offset.
// ---------------------------------------------------------------------------
// channel  signals                                    direction
// input    start busy opcode word_data block_number   in (busy out)
// result   done status present ones_before image_offset out
// config   cfg_we cfg_index cfg_data                  in
// A rejected transfer answers on the next cycle; an append writes its word in S_APP.
// A query does a group search by repeated addition of the group size, reads
// the group's prefix count, walks the words before the block's word inside
// its group (one RAM read a cycle through the popcount adder), then
// multiplies, waits on the bit-serial divider and sums the offset.
// Reset clears counts and result registers; the stores are undefined until written.
// The result is shown for one cycle on done; the receiver cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sparse_image_block_offset_rank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [63:0] word_data,
    input  logic [15:0] block_number,
    output logic        done,
    output logic [1:0]  status,
    output logic        present,
    output logic [16:0] ones_before,
    output logic [47:0] image_offset,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int AW = sibor_pkg::ADDR_W;
    localparam int CW = sibor_pkg::CNT_W;
    localparam int RW = sibor_pkg::RANK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_APP, S_QGRP, S_QPRE, S_QWALK, S_QMUL1, S_QDIV,
        S_QMUL2, S_QSUM
    } state_t;

    state_t state_reg;
    logic [24:0] bs_reg;
    logic [6:0]  cs_reg;
    logic [20:0] bpc_reg;
    logic [31:0] doff_reg;
    logic [10:0] wpg_reg;

    logic [CW-1:0] loaded_reg;
    logic [RW-1:0] total_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] gidx_reg;

    logic [63:0]   word_reg;
    logic [15:0]   blk_reg;
    logic [AW-1:0] widx_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] g_reg;
    logic [AW-1:0] first_reg;
    logic [RW-1:0] rank_reg;
    logic [47:0]   acc_reg;
    logic [1:0]    status_reg;
    logic          present_reg;
    logic          done_reg;

    logic          bm_we, pf_we, div_go, div_done;
    logic [AW-1:0] bm_addr, pf_addr;
    logic [63:0]   bm_rdata;
    logic [RW-1:0] pf_rdata, quot;
    logic [10:0]   gs;
    logic [20:0]   bpc;
    logic [63:0]   mask;
    logic [5:0]    bitpos;
    logic [41:0]   prod;
    logic [23:0]   prod2;

    assign gs     = (wpg_reg == 11'd0) ? 11'd1 : wpg_reg;
    assign bpc    = (bpc_reg == 21'd0) ? 21'd1 : bpc_reg;
    assign bitpos = blk_reg[5:0];
    assign mask   = (64'd1 << bitpos) - 64'd1;
    assign prod   = rank_reg * bs_reg;
    assign prod2  = quot * cs_reg;

    assign bm_we   = (state_reg == S_APP);
    assign pf_we   = (state_reg == S_APP) && (pos_reg == '0);
    assign bm_addr = (state_reg == S_APP) ? loaded_reg[AW-1:0] : addr_reg;
    assign pf_addr = (state_reg == S_APP) ? gidx_reg : g_reg;
    assign div_go  = (state_reg == S_QMUL1);

    sibor_ram #(.WIDTH(64), .DEPTH(sibor_pkg::MAX_WORDS)) u_bitmap (
        .clk(clk), .we(bm_we), .addr(bm_addr), .wdata(word_reg), .rdata(bm_rdata)
    );
    sibor_ram #(.WIDTH(RW), .DEPTH(sibor_pkg::MAX_WORDS)) u_prefix (
        .clk(clk), .we(pf_we), .addr(pf_addr), .wdata(total_reg), .rdata(pf_rdata)
    );
    sibor_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(rank_reg), .divisor(bpc),
        .done(div_done), .quotient(quot)
    );

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign present      = present_reg;
    assign ones_before  = (status_reg == sibor_pkg::ST_OK) ? rank_reg : '0;
    assign image_offset = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg      <= 25'd4096;
            cs_reg      <= 7'd4;
            bpc_reg     <= 21'd1;
            doff_reg    <= '0;
            wpg_reg     <= 11'd16;
            state_reg   <= S_IDLE;
            loaded_reg  <= '0;
            total_reg   <= '0;
            pos_reg     <= '0;
            gidx_reg    <= '0;
            done_reg    <= 1'b0;
            status_reg  <= '0;
            present_reg <= 1'b0;
            rank_reg    <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sibor_pkg::REG_BLK_BYTES:     bs_reg   <= cfg_data[24:0];
                    sibor_pkg::REG_CK_BYTES:      cs_reg   <= cfg_data[6:0];
                    sibor_pkg::REG_BLOCKS_PER_CK: bpc_reg  <= cfg_data[20:0];
                    sibor_pkg::REG_DATA_BASE:     doff_reg <= cfg_data;
                    sibor_pkg::REG_WORDS_PER_GRP: wpg_reg  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        word_reg    <= word_data;
                        blk_reg     <= block_number;
                        widx_reg    <= block_number[15:6];
                        rank_reg    <= '0;
                        acc_reg     <= '0;
                        present_reg <= 1'b0;
                        if (opcode == sibor_pkg::OP_APPEND)
                        begin
                            if (loaded_reg >= CW'(sibor_pkg::MAX_WORDS))
                            begin
                                status_reg <= sibor_pkg::ST_FULL;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                status_reg <= sibor_pkg::ST_OK;
                                state_reg  <= S_APP;
                            end
                        end
                        else if ({6'd0, block_number[15:6]} >= 16'(loaded_reg))
                        begin
                            status_reg <= sibor_pkg::ST_BEYOND;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= sibor_pkg::ST_OK;
                            g_reg      <= '0;
                            first_reg  <= '0;
                            state_reg  <= S_QGRP;
                        end
                    end
                end
                S_APP:
                begin
                    total_reg  <= total_reg + RW'(sibor_pkg::popcount(word_reg));
                    loaded_reg <= loaded_reg + CW'(1);
                    if ({1'b0, pos_reg} + 11'd1 >= gs)
                    begin
                        pos_reg  <= '0;
                        gidx_reg <= gidx_reg + AW'(1);
                    end
                    else
                    begin
                        pos_reg <= pos_reg + AW'(1);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_QGRP:
                begin
                    // group search by repeated add of the group size
                    if ({1'b0, first_reg} + gs > {1'b0, widx_reg})
                    begin
                        addr_reg  <= first_reg;
                        state_reg <= S_QPRE;
                    end
                    else
                    begin
                        first_reg <= AW'({1'b0, first_reg} + gs);
                        g_reg     <= g_reg + AW'(1);
                    end
                end
                S_QPRE:
                begin
                    rank_reg <= pf_rdata;
                    if (addr_reg != widx_reg)
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                    state_reg <= S_QWALK;
                end
                S_QWALK:
                begin
                    // bm_rdata holds the word at first_reg; addr_reg runs one ahead
                    if (first_reg == widx_reg)
                    begin
                        rank_reg    <= rank_reg + RW'(sibor_pkg::popcount(bm_rdata & mask));
                        present_reg <= bm_rdata[bitpos];
                        state_reg   <= S_QMUL1;
                    end
                    else
                    begin
                        rank_reg  <= rank_reg + RW'(sibor_pkg::popcount(bm_rdata));
                        first_reg <= first_reg + AW'(1);
                        if (addr_reg != widx_reg)
                        begin
                            addr_reg <= addr_reg + AW'(1);
                        end
                    end
                end
                S_QMUL1:
                begin
                    acc_reg   <= 48'(prod) + 48'(doff_reg);
                    state_reg <= S_QDIV;
                end
                S_QDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_QMUL2;
                    end
                end
                S_QMUL2:
                begin
                    acc_reg   <= acc_reg + 48'(prod2);
                    state_reg <= S_QSUM;
                end
                S_QSUM:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/sibor_checker.sv
// ---------------------------------------------------------------------------
// sibor_checker
// Port-level checks on the block offset unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_image_block_offset_rank_defines.svh"
module sibor_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic        present,
    input logic [16:0] ones_before,
    input logic [47:0] image_offset
);
    logic err_done;
    logic fields_zero;

    assign err_done    = done && (status != sibor_pkg::ST_OK);
    assign fields_zero = !present && (ones_before == '0) && (image_offset == '0);

    `SIBOR_ASSERT_NXT(a_busy_after_start, start && !busy, busy || done)
    `SIBOR_ASSERT_IMP(a_done_pulse, done, $past(busy) || $past(start))
    `SIBOR_ASSERT_IMP(a_err_zero, err_done, fields_zero)
    `SIBOR_ASSERT_IMP(a_status_range, done, status != 2'd3)
endmodule

bind sparse_image_block_offset_rank sibor_checker u_sibor_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .present(present), .ones_before(ones_before),
    .image_offset(image_offset)
);
